// ----- rtl/core/qwfi_pkg.sv -----
// Shared types and defaults for the queue with front insert and max promote.
package qwfi_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PUSHF = 2'd2,
    OP_MAXF  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_PRIME,
    S_SHIFT,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] key_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] key_out;
    status_t            status;
    logic [4:0]         count;
  } out_t;

endpackage

// ----- rtl/core/queue_with_front_insert_and_max_promote.sv -----
// Top level of the bounded key queue with front insert and max promote.
// Usage:
//   Each request on the in_ channel carries an operation (enqueue, dequeue,
//   push front, move greatest key to front) and a key. Exactly one result
//   leaves on the out_ channel per request: key, status and key count.
//   Requests are handled one at a time; in_ready is low while one is in work.
//   Enqueue, push front and refused requests go from acceptance straight to
//   the result state and from there to the output register; dequeue first
//   passes a read state. Move-max scans the stored keys through the single
//   read port and the shared comparator, then goes to the result state when
//   the greatest key is already at the front, or else primes a read, shifts
//   the keys ahead of it back by one place and writes it at the front.
//   The result sits in an output register, so a new request is accepted
//   while it waits; a stalled receiver holds the next finished result in the
//   sequencer until the register frees.
//   Synchronous reset empties the queue; the key store itself is not cleared.
module queue_with_front_insert_and_max_promote #(
  parameter int DEPTH     = qwfi_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = qwfi_pkg::KEY_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  qwfi_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output qwfi_pkg::out_t out_data
);
  import qwfi_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic                 res_valid;
  logic                 res_ready;
  out_t                 res_data;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;
  logic                 out_valid_r;
  out_t                 out_data_r;

  qwfi_ctrl #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  qwfi_ram #(
    .DEPTH (DEPTH),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in work");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && res_valid))
    else $error("sequencer offers a result while idle");

  a_refused_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL || out_data.status == ST_EMPTY)
      |-> out_data.key_out == '0)
    else $error("refused request returns a nonzero key");

  a_empty_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.count == '0)
    else $error("empty status with a nonzero count");

endmodule

// ----- rtl/core/qwfi_ram.sv -----
// Key store: one write port and one registered read port.
module qwfi_ram #(
  parameter int DEPTH = qwfi_pkg::DEPTH_DEF,
  parameter int WIDTH = qwfi_pkg::KEY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/qwfi_ctrl.sv -----
// Sequencer and shared compare datapath that run each queue operation.
module qwfi_ctrl #(
  parameter int DEPTH     = qwfi_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = qwfi_pkg::KEY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  qwfi_pkg::in_t            in_data,
  output logic                     res_valid,
  input  logic                     res_ready,
  output qwfi_pkg::out_t           res_data,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output logic [KEY_WIDTH-1:0]     mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  logic [KEY_WIDTH-1:0]     mem_rdata
);
  import qwfi_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     off_r, off_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [IDX_W-1:0]     w_r, w_nxt;
  logic [KEY_WIDTH-1:0] mx_r, mx_nxt;
  out_t                 res_r, res_nxt;

  logic                 full;
  logic                 empty;
  logic                 last;
  logic                 take;
  logic signed [63:0]   kin_ext;
  logic [KEY_WIDTH-1:0] kin;

  // Ring position of the entry that is off places behind hd.
  function automatic logic [IDX_W-1:0] slot(logic [IDX_W-1:0] hd, logic [IDX_W-1:0] off);
    logic [IDX_W:0] s;
    s = {1'b0, hd} + {1'b0, off};
    if (s >= (IDX_W + 1)'(DEPTH)) begin
      s = s - (IDX_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic signed [31:0] key_to_out(logic [KEY_WIDTH-1:0] k);
    logic signed [KEY_WIDTH-1:0] ks;
    logic signed [63:0]          w;
    ks = k;
    w  = 64'(ks);
    return w[31:0];
  endfunction

  function automatic logic [4:0] cnt_to_out(logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] ext;
    ext = {5'b0, c};
    return ext[4:0];
  endfunction

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign last    = ((CNT_W'(off_r) + CNT_W'(1)) == count_r);
  assign kin_ext = 64'(in_data.key_in);
  assign kin     = kin_ext[KEY_WIDTH-1:0];
  assign take    = (off_r == '0) || ($signed(mem_rdata) > $signed(mx_r));
  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    best_r <= best_nxt;
    w_r    <= w_nxt;
    mx_r   <= mx_nxt;
    res_r  <= res_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.op)
            OP_DEQ:  state_nxt = empty ? S_DONE : S_DEQ;
            OP_MAXF: state_nxt = empty ? S_DONE : S_SCAN;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DEQ:   state_nxt = S_DONE;
      S_SCAN: begin
        if (last) begin
          state_nxt = (best_nxt == '0) ? S_DONE : S_PRIME;
        end
      end
      S_PRIME: state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (w_r == IDX_W'(1)) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT:   state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and handshake outputs.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    off_nxt   = off_r;
    best_nxt  = best_r;
    w_nxt     = w_r;
    mx_nxt    = mx_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = head_r;
    mem_wdata = mx_r;
    mem_re    = 1'b0;
    mem_raddr = head_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.op)
            OP_ENQ: begin
              if (full) begin
                res_nxt = '{key_out: '0, status: ST_FULL, count: cnt_to_out(count_r)};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot(head_r, count_r[IDX_W-1:0]);
                mem_wdata = kin;
                count_nxt = count_r + CNT_W'(1);
                res_nxt   = '{key_out: '0, status: ST_OK, count: cnt_to_out(count_nxt)};
              end
            end
            OP_PUSHF: begin
              if (full) begin
                res_nxt = '{key_out: '0, status: ST_FULL, count: cnt_to_out(count_r)};
              end else begin
                head_nxt  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - IDX_W'(1);
                mem_we    = 1'b1;
                mem_waddr = head_nxt;
                mem_wdata = kin;
                count_nxt = count_r + CNT_W'(1);
                res_nxt   = '{key_out: '0, status: ST_OK, count: cnt_to_out(count_nxt)};
              end
            end
            default: begin
              // Dequeue and move-max both start by reading the front key.
              if (empty) begin
                res_nxt = '{key_out: '0, status: ST_EMPTY, count: cnt_to_out(count_r)};
              end else begin
                mem_re  = 1'b1;
                off_nxt = '0;
              end
            end
          endcase
        end
      end
      S_DEQ: begin
        head_nxt  = slot(head_r, IDX_W'(1));
        count_nxt = count_r - CNT_W'(1);
        res_nxt   = '{key_out: key_to_out(mem_rdata), status: ST_OK,
                      count: cnt_to_out(count_nxt)};
      end
      S_SCAN: begin
        // The data arriving now belongs to offset off_r; the next read is issued alongside.
        if (take) begin
          mx_nxt   = mem_rdata;
          best_nxt = off_r;
        end
        off_nxt   = off_r + IDX_W'(1);
        mem_re    = !last;
        mem_raddr = slot(head_r, off_nxt);
        if (last) begin
          w_nxt   = best_nxt;
          res_nxt = '{key_out: key_to_out(mx_nxt), status: ST_OK, count: cnt_to_out(count_r)};
        end
      end
      S_PRIME: begin
        mem_re    = 1'b1;
        mem_raddr = slot(head_r, w_r - IDX_W'(1));
      end
      S_SHIFT: begin
        // Each key ahead of the maximum moves one place back, from the back towards the front.
        mem_we    = 1'b1;
        mem_waddr = slot(head_r, w_r);
        mem_wdata = mem_rdata;
        mem_re    = (w_r >= IDX_W'(2));
        mem_raddr = slot(head_r, w_r - IDX_W'(2));
        w_nxt     = w_r - IDX_W'(1);
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = head_r;
        mem_wdata = mx_r;
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the bounded key queue with front insert and max promote.
module tb;
  import qwfi_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int RANDOM_REQUESTS = 400;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Behavioural copy of the queue contents.
  logic signed [31:0] queue_keys [QDEPTH];
  logic [3:0]         queue_head;
  int                 queue_fill;

  out_t      pending_results[$];
  stim_row_t stim_table[$];
  int        mismatches = 0;
  bit        send_burst;
  bit        recv_burst;

  queue_with_front_insert_and_max_promote u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request to the queue copy and returns the result it causes.
  function automatic out_t queue_apply(in_t r);
    out_t               res;
    int                 best;
    logic [3:0]         idx;
    logic signed [31:0] top;
    res.key_out = '0;
    res.status  = ST_OK;
    case (r.op)
      OP_ENQ: begin
        if (queue_fill >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          idx = queue_head + 4'(queue_fill);
          queue_keys[idx] = r.key_in;
          queue_fill++;
        end
      end
      OP_DEQ: begin
        if (queue_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key_out = queue_keys[queue_head];
          queue_head  = queue_head + 4'd1;
          queue_fill--;
        end
      end
      OP_PUSHF: begin
        if (queue_fill >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          queue_head = queue_head - 4'd1;
          queue_keys[queue_head] = r.key_in;
          queue_fill++;
        end
      end
      default: begin
        if (queue_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          best = 0;
          top  = queue_keys[queue_head];
          for (int i = 1; i < queue_fill; i++) begin
            idx = queue_head + 4'(i);
            if (queue_keys[idx] > top) begin
              top  = queue_keys[idx];
              best = i;
            end
          end
          for (int i = best; i > 0; i--) begin
            idx = queue_head + 4'(i);
            queue_keys[idx] = queue_keys[idx - 4'd1];
          end
          queue_keys[queue_head] = top;
          res.key_out = top;
        end
      end
    endcase
    res.count = 5'(queue_fill);
    return res;
  endfunction

  task automatic add_stim(op_t op, logic signed [31:0] key, bit typed,
                          logic signed [31:0] want_key, status_t want_status,
                          logic [4:0] want_count);
    stim_row_t row;
    row.req.op         = op;
    row.req.key_in     = key;
    row.typed          = typed;
    row.want.key_out   = want_key;
    row.want.status    = want_status;
    row.want.count     = want_count;
    stim_table.push_back(row);
  endtask

  // Presents one request after a random gap and records its expected result
  // once it is taken. Starts just after a rising edge, ends on the accepting one.
  task automatic send_request(in_t req, bit typed, out_t want);
    int   gap;
    out_t predicted;
    @(negedge clk);
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = queue_apply(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_pending();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_key();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2:    return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // The mix of operations leans towards filling or draining, or is evenly
  // spread, so that the queue spends time both near empty and near full.
  function automatic op_t random_op(int lean);
    int r;
    r = $urandom_range(0, 99);
    case (lean)
      0:       return r < 35 ? OP_ENQ : r < 60 ? OP_PUSHF : r < 75 ? OP_DEQ : OP_MAXF;
      1:       return r < 15 ? OP_ENQ : r < 25 ? OP_PUSHF : r < 70 ? OP_DEQ : OP_MAXF;
      default: return op_t'(r % 4);
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: key %0d status %0d count %0d",
                   out_data.key_out, out_data.status, out_data.count);
      end else begin
        want = pending_results.pop_front();
        if (out_data.key_out !== want.key_out || out_data.status !== want.status ||
            out_data.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: key %0d/%0d status %0d/%0d count %0d/%0d (exp/got)",
                     want.key_out, out_data.key_out, want.status, out_data.status,
                     want.count, out_data.count);
        end
      end
    end
  end

  // Receiver: stalls at random before taking each result, but not during bursts.
  initial begin : receiver
    int stall;
    int taken;
    taken = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (taken % 32 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    in_t  req;
    out_t unused;
    int   lean;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    send_burst = 1'b0;
    unused     = '0;
    queue_head = '0;
    queue_fill = 0;
    foreach (queue_keys[i]) queue_keys[i] = '0;

    // Empty queue, extreme keys, promotion from behind, greatest already in
    // front, a tie, then filling up to the refusals at full.
    add_stim(OP_DEQ,   32'sd0,        1'b1, 32'sd0,        ST_EMPTY, 5'd0);
    add_stim(OP_MAXF,  32'sd0,        1'b1, 32'sd0,        ST_EMPTY, 5'd0);
    add_stim(OP_ENQ,   32'sh7fffffff, 1'b1, 32'sd0,        ST_OK,    5'd1);
    add_stim(OP_ENQ,   32'sh80000000, 1'b1, 32'sd0,        ST_OK,    5'd2);
    add_stim(OP_PUSHF, 32'sd0,        1'b1, 32'sd0,        ST_OK,    5'd3);
    add_stim(OP_MAXF,  32'sd0,        1'b1, 32'sh7fffffff, ST_OK,    5'd3);
    add_stim(OP_MAXF,  32'sh12345678, 1'b1, 32'sh7fffffff, ST_OK,    5'd3);
    add_stim(OP_DEQ,   32'sd0,        1'b1, 32'sh7fffffff, ST_OK,    5'd2);
    add_stim(OP_ENQ,   32'sd5,        1'b0, 32'sd0,        ST_OK,    5'd0);
    add_stim(OP_ENQ,   32'sd5,        1'b0, 32'sd0,        ST_OK,    5'd0);
    add_stim(OP_PUSHF, -32'sd3,       1'b0, 32'sd0,        ST_OK,    5'd0);
    add_stim(OP_MAXF,  32'sd0,        1'b0, 32'sd0,        ST_OK,    5'd0);
    for (int i = 0; i < 11; i++)
      add_stim(OP_ENQ, (i % 2) ? 32'sh55555555 - i : -32'sh2aaaaaab + i,
               1'b0, 32'sd0, ST_OK, 5'd0);
    add_stim(OP_ENQ,   32'sh7fffffff, 1'b1, 32'sd0,        ST_FULL,  5'd16);
    add_stim(OP_PUSHF, 32'sh80000000, 1'b1, 32'sd0,        ST_FULL,  5'd16);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i])
      send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
    drain_pending();

    lean = 2;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 20 == 0) lean = $urandom_range(0, 2);
      if (n % 32 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n % 100 == 50) drain_pending();
      req.op     = random_op(lean);
      req.key_in = random_key();
      send_request(req, 1'b0, unused);
    end
    drain_pending();
    repeat (2 * QDEPTH + 8) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/qwfi_pkg.sv
rtl/core/qwfi_ram.sv
rtl/core/qwfi_ctrl.sv
rtl/core/queue_with_front_insert_and_max_promote.sv
sim/tb.sv
